[src/shbb_pkg.sv]
// Package for the staged heater bang-bang controller.
// Holds mode/phase codes, shared structs and field widths; no dependencies.
`timescale 1ns / 1ps

package shbb_pkg;

	localparam int TEMP_W     = 15;
	localparam int TARGET_W   = 14;
	localparam int OFFSET_W   = 9;
	localparam int SECONDS_W  = 19;
	localparam int INTERVAL_W = 16;
	localparam int CMP_W      = 16;  // signed width for temperature compares
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 19;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	localparam logic [INTERVAL_W-1:0] ELAPSED_MAX = {INTERVAL_W{1'b1}};

	// Register indexes of the configuration port
	localparam logic [CFG_ADDR_W-1:0] REG_TARGET = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_OFFSET = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_COOK   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SHORT  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_PEAK   = 3'd4;

	// Reset values of the configuration registers
	localparam logic [TARGET_W-1:0]   TARGET_RST = 14'd5000;
	localparam logic [OFFSET_W-1:0]   OFFSET_RST = 9'd66;
	localparam logic [SECONDS_W-1:0]  COOK_RST   = 19'd3600;
	localparam logic [INTERVAL_W-1:0] SHORT_RST  = 16'd1000;
	localparam logic [INTERVAL_W-1:0] PEAK_RST   = 16'd60000;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_COOK = 2'd1,
		MODE_DONE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		PH_PREHEAT = 2'd0,
		PH_PEAK    = 2'd1,
		PH_HOLD    = 2'd2
	} phase_t;

	typedef struct packed {
		logic [TARGET_W-1:0]   target;
		logic [OFFSET_W-1:0]   offset;
		logic [SECONDS_W-1:0]  cook_seconds;
		logic [INTERVAL_W-1:0] short_interval;
		logic [INTERVAL_W-1:0] peak_interval;
	} cfg_t;

	typedef struct packed {
		mode_t                     mode;
		phase_t                    phase;
		logic [SECONDS_W-1:0]      countdown;
		logic [INTERVAL_W-1:0]     elapsed;
		logic signed [TEMP_W-1:0]  held;
		logic signed [TEMP_W-1:0]  prior;
		logic                      relay;
	} ctl_state_t;

	typedef struct packed {
		logic                      heater_on;
		mode_t                     cook_mode;
		phase_t                    heat_phase;
		logic [SECONDS_W-1:0]      seconds_left;
		logic signed [TEMP_W-1:0]  sampled_temp_centi;
		logic                      sample_taken;
	} result_t;

endpackage

[src/staged_heater_bang_bang_controller.sv]
// Staged heater bang-bang controller, one transaction per millisecond tick.
// The input transaction is held in the input register, its result in the result register.
// Throughput: one transaction per cycle while the result side accepts; the cook state is registered and fed back.
// Reset (arst_n low, asynchronous): idle, preheat, heater off, counters and samples
// cleared, configuration registers back to their defaults. Depends on shbb_pkg.
`timescale 1ns / 1ps

module staged_heater_bang_bang_controller import shbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [14:0] temperature_centi, [15] button_press, [16] second_pulse, [23:17] zero
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [0] heater_on, [2:1] cook_mode, [4:3] heat_phase, [23:5] seconds_left,
	// [38:24] sampled_temp_centi, [39] sample_taken
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg;

	shbb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.addr   (cfg_addr),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	// Stage 1: registered input transaction
	logic                     valid_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic                     press_s1;
	logic                     pulse_s1;

	// Stage 2: result register feeding the master side
	logic                     valid_s2;
	result_t                  res_s2;

	// Cook state, updated once per processed tick
	ctl_state_t               state_q;
	ctl_state_t               state_nxt;
	result_t                  res_nxt;

	logic                     advance;
	logic                     in_accept;

	// Stage 1 moves on whenever the result register is empty or being drained,
	// so a waiting result never blocks the next input transaction by itself.
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			temp_s1  <= s_axis_tdata[TEMP_W-1:0];
			press_s1 <= s_axis_tdata[TEMP_W];
			pulse_s1 <= s_axis_tdata[TEMP_W+1];
		end
	end

	shbb_step u_step (
		.cur   (state_q),
		.cfg   (cfg),
		.temp  (temp_s1),
		.press (press_s1),
		.pulse (pulse_s1),
		.nxt   (state_nxt),
		.res   (res_nxt)
	);

	// State commits exactly when its tick's result is written to stage 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode      <= MODE_IDLE;
			state_q.phase     <= PH_PREHEAT;
			state_q.countdown <= '0;
			state_q.elapsed   <= '0;
			state_q.held      <= '0;
			state_q.prior     <= '0;
			state_q.relay     <= 1'b0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= 1'b1;
		else if (m_axis_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_nxt;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {res_s2.sample_taken,
	                        res_s2.sampled_temp_centi,
	                        res_s2.seconds_left,
	                        res_s2.heat_phase,
	                        res_s2.cook_mode,
	                        res_s2.heater_on};

endmodule

[src/shbb_cfg.sv]
// Configuration register file of the heater controller.
// Depends on shbb_pkg for register indexes, widths and reset values.
`timescale 1ns / 1ps

module shbb_cfg import shbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_ADDR_W-1:0] addr,
	input  logic [CFG_DATA_W-1:0] wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target         <= TARGET_RST;
			cfg_q.offset         <= OFFSET_RST;
			cfg_q.cook_seconds   <= COOK_RST;
			cfg_q.short_interval <= SHORT_RST;
			cfg_q.peak_interval  <= PEAK_RST;
		end else if (we) begin
			unique case (addr)
				REG_TARGET: cfg_q.target         <= wdata[TARGET_W-1:0];
				REG_OFFSET: cfg_q.offset         <= wdata[OFFSET_W-1:0];
				REG_COOK:   cfg_q.cook_seconds   <= wdata[SECONDS_W-1:0];
				REG_SHORT:  cfg_q.short_interval <= wdata[INTERVAL_W-1:0];
				REG_PEAK:   cfg_q.peak_interval  <= wdata[INTERVAL_W-1:0];
				default: ;  // unused indexes are dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/shbb_step.sv]
// Next-state and result logic of the heater controller for one tick.
// Purely combinational; depends on shbb_pkg for types and codes.
`timescale 1ns / 1ps

module shbb_step import shbb_pkg::*; (
	input  ctl_state_t               cur,
	input  cfg_t                     cfg,
	input  logic signed [TEMP_W-1:0] temp,
	input  logic                     press,
	input  logic                     pulse,
	output ctl_state_t               nxt,
	output result_t                  res
);

	logic                    took;
	logic [INTERVAL_W-1:0]   interval;
	logic [INTERVAL_W-1:0]   elapsed_inc;
	logic                    due;
	logic signed [CMP_W-1:0] temp_x;
	logic signed [CMP_W-1:0] target_x;
	logic signed [CMP_W-1:0] threshold;

	// interval timer: saturating increment, sample when past the interval
	assign interval    = (cur.phase == PH_PEAK) ? cfg.peak_interval : cfg.short_interval;
	assign elapsed_inc = (cur.elapsed == ELAPSED_MAX) ? ELAPSED_MAX
	                                                  : cur.elapsed + 1'b1;
	assign due         = elapsed_inc > interval;

	assign temp_x    = CMP_W'(temp);
	assign target_x  = signed'({{(CMP_W-TARGET_W){1'b0}}, cfg.target});
	assign threshold = target_x - signed'({{(CMP_W-OFFSET_W){1'b0}}, cfg.offset});

	// next state
	always_comb begin
		nxt  = cur;
		took = 1'b0;
		unique case (cur.mode)
			MODE_IDLE: begin
				if (press) begin
					nxt.mode      = MODE_COOK;
					nxt.phase     = PH_PREHEAT;
					nxt.countdown = cfg.cook_seconds;
					nxt.elapsed   = '0;
					nxt.prior     = '0;
					nxt.held      = temp;
					nxt.relay     = 1'b1;
					took          = 1'b1;
				end
			end
			MODE_COOK: begin
				if (press) begin
					nxt.mode  = MODE_IDLE;
					nxt.phase = PH_PREHEAT;
					nxt.relay = 1'b0;
				end else begin
					nxt.elapsed = due ? '0 : elapsed_inc;
					if (due) begin
						nxt.held = temp;
						took     = 1'b1;
					end
					case (cur.phase)
						PH_PREHEAT: begin
							if (due && temp_x > threshold) begin
								nxt.phase   = PH_PEAK;
								nxt.elapsed = ELAPSED_MAX;
								nxt.relay   = 1'b0;
							end
						end
						PH_PEAK: begin
							if (due) begin
								nxt.prior = temp;
								if (temp < cur.prior) begin
									nxt.phase   = PH_HOLD;
									nxt.elapsed = ELAPSED_MAX;
								end
							end
						end
						default: begin
							if (due)
								nxt.relay = temp_x < target_x;
						end
					endcase
					// countdown only moves if hold was the phase at tick start
					if (pulse && cur.phase == PH_HOLD && cur.countdown != '0)
						nxt.countdown = cur.countdown - 1'b1;
					if (nxt.countdown == '0) begin
						nxt.mode  = MODE_DONE;
						nxt.relay = 1'b0;
					end
				end
			end
			MODE_DONE: begin
				if (press) begin
					nxt.mode  = MODE_IDLE;
					nxt.phase = PH_PREHEAT;
					nxt.relay = 1'b0;
				end
			end
			default: nxt = cur;
		endcase
	end

	// result fields
	always_comb begin
		res.heater_on          = nxt.relay;
		res.cook_mode          = nxt.mode;
		res.heat_phase         = nxt.phase;
		res.seconds_left       = nxt.countdown;
		res.sampled_temp_centi = nxt.held;
		res.sample_taken       = took;
	end

endmodule

[bench/tb_top.sv]
// Self-checking bench for staged_heater_bang_bang_controller: cook sequences, stop/done
// presses and interval extremes, with bursty input and a stalling result side.
// Depends on shbb_pkg and the controller RTL only.
`timescale 1ns / 1ps

module tb_top;
	import shbb_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction on either side
	localparam int SETTLE_CYCLES  = 6;     // pipeline is two deep, leave margin
	localparam int PHASE_ITEMS    = 150;
	localparam int RANDOM_PHASES  = 8;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_LONG
	} stall_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// [14:0] temperature_centi, [15] button_press, [16] second_pulse, [23:17] zero
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [0] heater_on, [2:1] cook_mode, [4:3] heat_phase, [23:5] seconds_left,
	// [38:24] sampled_temp_centi, [39] sample_taken
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	staged_heater_bang_bang_controller uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Controller mirror: settings and cook state as the block should hold them
	// ------------------------------------------------------------------
	logic [TARGET_W-1:0]      set_target;
	logic [OFFSET_W-1:0]      set_offset;
	logic [SECONDS_W-1:0]     set_cook;
	logic [INTERVAL_W-1:0]    set_short;
	logic [INTERVAL_W-1:0]    set_peak;

	mode_t                    ctl_mode;
	phase_t                   ctl_phase;
	logic [SECONDS_W-1:0]     ctl_countdown;
	logic [INTERVAL_W-1:0]    ctl_elapsed;
	logic signed [TEMP_W-1:0] ctl_held;
	logic signed [TEMP_W-1:0] ctl_prior;
	logic                     ctl_relay;

	result_t expected_status[$];  // one status word per accepted tick, oldest first

	int err_count   = 0;
	int status_seen = 0;
	int idle_cycles = 0;
	int burst_left  = 0;
	bit gaps_enabled = 1'b1;

	// Interval timer: bump (saturating), fire when strictly past the interval.
	// 65535 therefore never fires, zero fires every tick.
	function automatic bit interval_elapsed(input logic [INTERVAL_W-1:0] interval);
		if (ctl_elapsed != ELAPSED_MAX)
			ctl_elapsed++;
		if (ctl_elapsed > interval) begin
			ctl_elapsed = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic clear_controller();
		set_target    = TARGET_RST;
		set_offset    = OFFSET_RST;
		set_cook      = COOK_RST;
		set_short     = SHORT_RST;
		set_peak      = PEAK_RST;
		ctl_mode      = MODE_IDLE;
		ctl_phase     = PH_PREHEAT;
		ctl_countdown = '0;
		ctl_elapsed   = '0;
		ctl_held      = '0;
		ctl_prior     = '0;
		ctl_relay     = 1'b0;
	endtask

	// Apply one millisecond tick to the mirror and queue the status it must produce
	task automatic advance_controller(input logic signed [TEMP_W-1:0] temp,
	                                  input logic press, input logic pulse);
		result_t st;
		bit      took;
		bit      was_hold;
		int      temp_i;
		int      threshold;
		took      = 1'b0;
		temp_i    = temp;
		threshold = int'(set_target) - int'(set_offset);
		case (ctl_mode)
			MODE_IDLE: begin
				if (press) begin
					// cook start: no phase work this tick, sample taken
					ctl_mode      = MODE_COOK;
					ctl_phase     = PH_PREHEAT;
					ctl_countdown = set_cook;
					ctl_elapsed   = '0;
					ctl_prior     = '0;
					ctl_held      = temp;
					took          = 1'b1;
					ctl_relay     = 1'b1;
				end
			end
			MODE_COOK: begin
				if (press) begin
					// stop: countdown keeps its value
					ctl_mode  = MODE_IDLE;
					ctl_phase = PH_PREHEAT;
					ctl_relay = 1'b0;
				end else begin
					was_hold = (ctl_phase == PH_HOLD);
					case (ctl_phase)
						PH_PREHEAT: begin
							if (interval_elapsed(set_short)) begin
								ctl_held = temp;
								took     = 1'b1;
								if (temp_i > threshold) begin
									ctl_phase   = PH_PEAK;
									ctl_elapsed = ELAPSED_MAX;
									ctl_relay   = 1'b0;
								end
							end
						end
						PH_PEAK: begin
							if (interval_elapsed(set_peak)) begin
								ctl_held = temp;
								took     = 1'b1;
								if (temp_i < int'(ctl_prior)) begin
									ctl_phase   = PH_HOLD;
									ctl_elapsed = ELAPSED_MAX;
								end
								ctl_prior = temp;
							end
						end
						default: begin
							if (interval_elapsed(set_short)) begin
								ctl_held  = temp;
								took      = 1'b1;
								ctl_relay = (temp_i < int'(set_target));
							end
						end
					endcase
					// seconds only count in hold, and never below zero
					if (pulse && was_hold && ctl_countdown != 0)
						ctl_countdown--;
					if (ctl_countdown == 0) begin
						ctl_mode  = MODE_DONE;
						ctl_relay = 1'b0;
					end
				end
			end
			default: begin
				if (press) begin
					ctl_mode  = MODE_IDLE;
					ctl_phase = PH_PREHEAT;
					ctl_relay = 1'b0;
				end
			end
		endcase
		st.heater_on          = ctl_relay;
		st.cook_mode          = ctl_mode;
		st.heat_phase         = ctl_phase;
		st.seconds_left       = ctl_countdown;
		st.sampled_temp_centi = ctl_held;
		st.sample_taken       = took;
		expected_status.push_back(st);
	endtask

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------

	// Send one tick as a transaction. Called at a rising edge; returns at the edge
	// where the transaction took place, with tvalid still high.
	task automatic send_tick(input logic signed [TEMP_W-1:0] temp,
	                         input logic press, input logic pulse);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_enabled) begin
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W - TEMP_W - 2){1'b0}}, pulse, press, temp};
		do
			@(posedge clk);
		while (!s_axis_tready);
		advance_controller(temp, press, pulse);
	endtask

	// Stop sending and let every queued status come back, then a few more cycles
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all five registers on consecutive edges; only while settled
	task automatic write_settings(input int unsigned target,
	                              input int unsigned offset,
	                              input int unsigned cook,
	                              input int unsigned short_ms,
	                              input int unsigned peak_ms);
		logic [CFG_ADDR_W-1:0] idx [5];
		logic [CFG_DATA_W-1:0] val [5];
		idx = '{REG_TARGET, REG_OFFSET, REG_COOK, REG_SHORT, REG_PEAK};
		val = '{CFG_DATA_W'(target), CFG_DATA_W'(offset), CFG_DATA_W'(cook),
		        CFG_DATA_W'(short_ms), CFG_DATA_W'(peak_ms)};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
			case (idx[i])
				REG_TARGET: set_target = val[i][TARGET_W-1:0];
				REG_OFFSET: set_offset = val[i][OFFSET_W-1:0];
				REG_COOK:   set_cook   = val[i][SECONDS_W-1:0];
				REG_SHORT:  set_short  = val[i][INTERVAL_W-1:0];
				default:    set_peak   = val[i][INTERVAL_W-1:0];
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result side: stall pattern, checker, watchdog
	// ------------------------------------------------------------------
	stall_style_t stall_style = STALL_NONE;
	logic [7:0]   stall_tick  = '0;
	int           stall_hold  = 0;

	// Style changes each time stall_tick wraps; the long style throws in long random stalls
	always @(posedge clk) begin
		stall_tick <= stall_tick + 8'd1;
		if (stall_tick == 8'd0)
			stall_style <= stall_style_t'($urandom_range(0, 3));
		case (stall_style)
			STALL_NONE:     m_axis_tready <= 1'b1;
			STALL_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: m_axis_tready <= (stall_tick[2:0] < 3'd5);
			default: begin
				if (stall_hold != 0) begin
					stall_hold    <= stall_hold - 1;
					m_axis_tready <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					stall_hold    <= $urandom_range(5, 30);
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		endcase
	end

	task automatic report_mismatch(input string field, input int got, input int want);
		err_count++;
		$display("[%0t] status %0d: %s got %0d, expected %0d",
		         $realtime, status_seen, field, got, want);
	endtask

	// Values read at the edge are the ones before it, so the transaction is seen race-free
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_status.size() == 0) begin
				report_mismatch("unexpected transaction, heater_on",
				                int'(m_axis_tdata[0]), -1);
			end else begin
				want = expected_status.pop_front();
				if (m_axis_tdata[0] !== want.heater_on)
					report_mismatch("heater_on", int'(m_axis_tdata[0]),
					                int'(want.heater_on));
				if (m_axis_tdata[2:1] !== want.cook_mode)
					report_mismatch("cook_mode", int'(m_axis_tdata[2:1]),
					                int'(want.cook_mode));
				if (m_axis_tdata[4:3] !== want.heat_phase)
					report_mismatch("heat_phase", int'(m_axis_tdata[4:3]),
					                int'(want.heat_phase));
				if (m_axis_tdata[23:5] !== want.seconds_left)
					report_mismatch("seconds_left", int'(m_axis_tdata[23:5]),
					                int'(want.seconds_left));
				if (m_axis_tdata[38:24] !== want.sampled_temp_centi)
					report_mismatch("sampled_temp_centi",
					                int'($signed(m_axis_tdata[38:24])),
					                int'(want.sampled_temp_centi));
				if (m_axis_tdata[39] !== want.sample_taken)
					report_mismatch("sample_taken", int'(m_axis_tdata[39]),
					                int'(want.sample_taken));
			end
			status_seen++;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset settings: 1000 ms interval, so a short cook shows no sampling after the start sample
	task automatic test_power_on_defaults();
		send_tick(15'sd16383, 1'b0, 1'b1);   // pulse in idle is ignored
		send_tick(-15'sd16384, 1'b0, 1'b0);
		send_tick(15'sd2000, 1'b1, 1'b1);    // start with the default countdown
		send_tick(15'sd2100, 1'b0, 1'b1);    // pulse outside hold does nothing
		send_tick(15'sd2200, 1'b0, 1'b0);
		send_tick(15'sd2300, 1'b1, 1'b0);    // stop press
	endtask

	// Every phase in turn: preheat, peak search, hold, countdown to done, press out
	task automatic test_cook_walkthrough();
		settle();
		write_settings(5000, 100, 2, 0, 1);
		send_tick(15'sd4000, 1'b1, 1'b0);    // start, sample taken
		send_tick(15'sd4500, 1'b0, 1'b0);    // preheat sample, below threshold
		send_tick(15'sd4950, 1'b0, 1'b1);    // crosses target - offset: peak search
		send_tick(15'sd5100, 1'b0, 1'b0);    // forced sample after phase change
		send_tick(15'sd5050, 1'b0, 1'b0);    // interval not yet elapsed
		send_tick(15'sd5050, 1'b0, 1'b0);    // falling sample: hold
		send_tick(15'sd4990, 1'b0, 1'b1);    // below target: heater on, one second off
		send_tick(15'sd5010, 1'b0, 1'b1);    // countdown hits zero: done
		send_tick(15'sd5010, 1'b0, 1'b1);    // done ignores pulses
		send_tick(15'sd5010, 1'b1, 1'b0);    // press leaves done
	endtask

	// Zero countdown ends the cook the tick after start; negative threshold
	task automatic test_zero_countdown();
		settle();
		write_settings(0, 511, 0, 0, 0);
		send_tick(-15'sd600, 1'b1, 1'b0);
		send_tick(-15'sd400, 1'b0, 1'b1);
		send_tick(-15'sd400, 1'b0, 1'b0);
		send_tick(-15'sd400, 1'b1, 1'b0);
	endtask

	// Largest interval never elapses; largest target and countdown
	task automatic test_frozen_interval();
		settle();
		write_settings(16383, 0, 524287, 65535, 65535);
		send_tick(15'sd16383, 1'b1, 1'b0);
		send_tick(15'sd16383, 1'b0, 1'b1);
		send_tick(-15'sd1, 1'b0, 1'b0);
		send_tick(15'sd0, 1'b1, 1'b1);
	endtask

	// Closed-loop random cooks: the water follows the expected relay, with noise
	// ticks and stray presses mixed in
	task automatic test_random_cooks();
		int   plant;
		logic signed [TEMP_W-1:0] temp;
		logic press;
		logic pulse;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			case (ph)
				0: write_settings(4500, 0, 1, 0, 0);
				1: write_settings(10000, 500, 8, 5, 8);
				2: write_settings(0, 511, $urandom_range(0, 3), 1, 2);
				3: write_settings(16383, 511, 524287, 2, 3);
				4: write_settings(7000, 66, 4, 3, 65535);
				default: write_settings($urandom_range(4500, 10000), $urandom_range(0, 500),
				                        $urandom_range(0, 8), $urandom_range(0, 5),
				                        $urandom_range(0, 8));
			endcase
			gaps_enabled = (ph % 3 != 1);
			plant = int'(set_target) - int'($urandom_range(0, 400));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ctl_relay)
					plant += $urandom_range(0, 40);
				else
					plant -= $urandom_range(0, 30);
				if (plant > 16383)
					plant = 16383;
				if (plant < -16384)
					plant = -16384;
				if ($urandom_range(0, 19) == 0)
					temp = TEMP_W'($urandom_range(0, 32767));
				else
					temp = plant[TEMP_W-1:0];
				case (ctl_mode)
					MODE_IDLE: press = ($urandom_range(0, 5) == 0);
					MODE_COOK: press = ($urandom_range(0, 199) == 0);
					default:   press = ($urandom_range(0, 2) == 0);
				endcase
				if ($urandom_range(0, 29) == 0)
					press = ~press;
				pulse = ($urandom_range(0, 2) == 0);
				send_tick(temp, press, pulse);
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_addr      = '0;
		cfg_wdata     = '0;
		clear_controller();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_power_on_defaults();
		test_cook_walkthrough();
		test_zero_countdown();
		test_frozen_interval();
		test_random_cooks();

		settle();
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
